### design/black_scholes_explicit_stencil_unit_assert.svh
// Assertion macros used by the stencil unit controller.
`ifndef BLACK_SCHOLES_EXPLICIT_STENCIL_UNIT_ASSERT_SVH
`define BLACK_SCHOLES_EXPLICIT_STENCIL_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define BSES_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("stencil unit assertion failed");

// Condition that must never be seen outside reset.
`define BSES_NEVER(lbl, cond) \
  `BSES_ASSERT(lbl, !(cond))

`endif

### design/bses_pkg.sv
// Package with shared types, constants and arithmetic helpers of the stencil unit.
package bses_pkg;

  localparam int unsigned GridDepth = 1024;
  localparam int unsigned IdxW      = $clog2(GridDepth);
  localparam int unsigned PtsW      = IdxW + 1;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_RUN   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    REG_VOLATILITY = 3'd0,
    REG_RATE       = 3'd1,
    REG_DELTA_T    = 3'd2,
    REG_TIME_STEPS = 3'd3,
    REG_GRID_PTS   = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    WSEL_ITEM,
    WSEL_RDATA,
    WSEL_STENCIL
  } wsel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_PRE0,
    ST_PRE1,
    ST_PRE2,
    ST_BND0,
    ST_BND1,
    ST_BND2,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_WAIT,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic            cur_we;
    logic            nxt_we;
    logic [IdxW-1:0] wr_addr;
    wsel_e           wsel;
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            rd_next;
    logic            pre0;
    logic            pre1;
    logic            pre2;
    logic            coef0;
    logic            coef1;
    logic            coef2;
    logic [2:0]      tap_ld;
    logic            mul_en;
    logic [IdxW-1:0] j;
  } dp_cmd_t;

  typedef struct packed {
    logic [31:0] rd_data;
  } dp_stat_t;

  function automatic logic [31:0] sat32(input logic signed [49:0] v);
    logic [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -50'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### design/bses_dp.sv
// Datapath: grid memories, coefficient arithmetic and the three-point stencil.
module bses_dp
  import bses_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [31:0] point_value_i,
  input  logic [17:0] volatility_i,
  input  logic [15:0] rate_i,
  input  logic [23:0] delta_t_i,
  output dp_stat_t    stat_o
);

  logic [31:0] cur_mem [GridDepth];
  logic [31:0] nxt_mem [GridDepth];
  logic [31:0] cur_rdata_q, nxt_rdata_q;
  logic        rsel_q;
  logic [31:0] rdata;
  logic [31:0] wdata;

  logic [35:0] vv_q;
  logic [41:0] phi_q, plo_q;
  logic [59:0] full;
  logic [27:0] alpha_q;
  logic [23:0] beta_q;
  logic [39:0] rdt;

  logic [19:0] jj_q;
  logic [47:0] a2_q;
  logic [33:0] bj_q;
  logic signed [49:0] dif, dif_h, kbv;
  logic [49:0] sum2;
  logic [31:0] ka_q, kb_q, kc_q;
  logic [31:0] tap_q [3];
  logic signed [63:0] p0_q, p1_q, p2_q;
  logic signed [65:0] ssum, srnd, sq;
  logic [31:0] result;

  assign rdata = rsel_q ? nxt_rdata_q : cur_rdata_q;
  assign stat_o.rd_data = rdata;

  always_comb begin
    ssum = {{2{p0_q[63]}}, p0_q} + {{2{p1_q[63]}}, p1_q} + {{2{p2_q[63]}}, p2_q};
    srnd = ssum + 66'sd8388608;
    sq = srnd >>> 24;
    result = sat32(sq[49:0]);
  end

  always_comb begin
    case (cmd_i.wsel)
      WSEL_ITEM:    wdata = point_value_i;
      WSEL_RDATA:   wdata = rdata;
      WSEL_STENCIL: wdata = result;
      default:      wdata = result;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cur_we) begin
      cur_mem[cmd_i.wr_addr] <= wdata;
    end
    if (cmd_i.nxt_we) begin
      nxt_mem[cmd_i.wr_addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      cur_rdata_q <= cur_mem[cmd_i.rd_addr];
      nxt_rdata_q <= nxt_mem[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsel_q <= 1'b0;
    end else if (cmd_i.rd_en) begin
      rsel_q <= cmd_i.rd_next;
    end
  end

  // alpha = (vol^2 * dt) >> 32, with the 36x24 product split in two halves.
  assign full = {phi_q, 18'b0} + {18'b0, plo_q};
  assign rdt  = {8'b0, rate_i} * {16'b0, delta_t_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.pre0) begin
      vv_q <= {18'b0, volatility_i} * {18'b0, volatility_i};
    end
    if (cmd_i.pre1) begin
      phi_q  <= {24'b0, vv_q[35:18]} * {18'b0, delta_t_i};
      plo_q  <= {24'b0, vv_q[17:0]} * {18'b0, delta_t_i};
      beta_q <= rdt[39:16];
    end
    if (cmd_i.pre2) begin
      alpha_q <= full[59:32];
    end
  end

  always_comb begin
    dif   = $signed({2'b0, a2_q}) - $signed({16'b0, bj_q});
    dif_h = (dif + $signed({49'b0, dif[49]})) >>> 1;
    kbv   = 50'sd16777216 - $signed({2'b0, a2_q}) - $signed({26'b0, beta_q});
    sum2  = {2'b0, a2_q} + {16'b0, bj_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef0) begin
      jj_q <= {10'b0, cmd_i.j} * {10'b0, cmd_i.j};
    end
    if (cmd_i.coef1) begin
      a2_q <= {20'b0, alpha_q} * {28'b0, jj_q};
      bj_q <= {10'b0, beta_q} * {24'b0, cmd_i.j};
    end
    if (cmd_i.coef2) begin
      ka_q <= sat32(dif_h);
      kb_q <= sat32(kbv);
      kc_q <= sat32($signed({1'b0, sum2[49:1]}));
    end
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.tap_ld[k]) begin
        tap_q[k] <= rdata;
      end
    end
    if (cmd_i.mul_en) begin
      p0_q <= $signed(ka_q) * $signed(tap_q[0]);
      p1_q <= $signed(kb_q) * $signed(tap_q[1]);
      p2_q <= $signed(kc_q) * $signed(tap_q[2]);
    end
  end

endmodule

### design/bses_ctrl.sv
// Controller: item handshake, run sequencing over passes and points, result register.
module bses_ctrl
  import bses_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      func_i,
  input  logic [IdxW-1:0] point_index_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [31:0]     read_value_o,
  output logic            status_o,
  input  logic [15:0]     time_steps_i,
  input  logic [PtsW-1:0] grid_points_i,
  output dp_cmd_t         cmd_o,
  input  dp_stat_t        stat_i
);

  `include "black_scholes_explicit_stencil_unit_assert.svh"

  state_e state_q, state_d;
  logic [IdxW-1:0] j_q, j_d;
  logic [15:0]     pairs_q, pairs_d;
  logic            dir_q, dir_d;
  logic            pass2_q, pass2_d;
  logic            out_valid_q;
  logic [31:0]     rv_q;
  logic            st_q;
  logic            out_ld;
  logic [31:0]     out_rv;
  logic            out_st;
  logic            accept;
  logic [PtsW-1:0] pts;
  logic [IdxW-1:0] last;
  logic [16:0]     ts_inc;
  logic            idx_bad;
  func_e           func;

  assign pts     = (grid_points_i > PtsW'(GridDepth)) ? PtsW'(GridDepth) : grid_points_i;
  assign last    = IdxW'(pts - PtsW'(1));
  assign ts_inc  = {1'b0, time_steps_i} + 17'd1;
  assign idx_bad = {1'b0, point_index_i} >= pts;
  assign func    = func_e'(func_i);

  assign in_stall_o   = !((state_q == ST_IDLE) && (!out_valid_q || !out_stall_i));
  assign accept       = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign read_value_o = rv_q;
  assign status_o     = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      j_q         <= '0;
      pairs_q     <= '0;
      dir_q       <= 1'b0;
      pass2_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      pairs_q <= pairs_d;
      dir_q   <= dir_d;
      pass2_q <= pass2_d;
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      rv_q <= out_rv;
      st_q <= out_st;
    end
  end

  always_comb begin
    state_d = state_q;
    j_d     = j_q;
    pairs_d = pairs_q;
    dir_d   = dir_q;
    pass2_d = pass2_q;
    out_ld  = 1'b0;
    out_rv  = '0;
    out_st  = 1'b0;
    cmd_o   = '0;
    cmd_o.wsel    = WSEL_STENCIL;
    cmd_o.j       = j_q;
    cmd_o.rd_next = dir_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func)
            FUNC_WRITE: begin
              cmd_o.cur_we  = !idx_bad;
              cmd_o.wr_addr = point_index_i;
              cmd_o.wsel    = WSEL_ITEM;
              out_ld = 1'b1;
              out_st = idx_bad;
            end
            FUNC_READ: begin
              if (idx_bad) begin
                out_ld = 1'b1;
                out_st = 1'b1;
              end else begin
                cmd_o.rd_en   = 1'b1;
                cmd_o.rd_addr = point_index_i;
                cmd_o.rd_next = 1'b0;
                state_d = ST_READ;
              end
            end
            FUNC_RUN: begin
              pairs_d = ts_inc[16:1];
              dir_d   = 1'b0;
              pass2_d = 1'b0;
              j_d     = IdxW'(1);
              if (pts < PtsW'(3) || ts_inc[16:1] == 16'd0) begin
                out_ld = 1'b1;
              end else begin
                state_d = ST_PRE0;
              end
            end
            default: begin
              out_ld = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_ld  = 1'b1;
        out_rv  = stat_i.rd_data;
        state_d = ST_IDLE;
      end
      ST_PRE0: begin
        cmd_o.pre0 = 1'b1;
        state_d = ST_PRE1;
      end
      ST_PRE1: begin
        cmd_o.pre1 = 1'b1;
        state_d = ST_PRE2;
      end
      ST_PRE2: begin
        cmd_o.pre2 = 1'b1;
        state_d = ST_BND0;
      end
      // The boundary points of the scratch grid are copied once per run.
      ST_BND0: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = '0;
        cmd_o.rd_next = 1'b0;
        state_d = ST_BND1;
      end
      ST_BND1: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = last;
        cmd_o.rd_next = 1'b0;
        cmd_o.nxt_we  = 1'b1;
        cmd_o.wr_addr = '0;
        cmd_o.wsel    = WSEL_RDATA;
        state_d = ST_BND2;
      end
      ST_BND2: begin
        cmd_o.nxt_we  = 1'b1;
        cmd_o.wr_addr = last;
        cmd_o.wsel    = WSEL_RDATA;
        state_d = ST_RD0;
      end
      ST_RD0: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = j_q - IdxW'(1);
        cmd_o.coef0   = 1'b1;
        state_d = ST_RD1;
      end
      ST_RD1: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = j_q;
        cmd_o.tap_ld  = 3'b001;
        cmd_o.coef1   = 1'b1;
        state_d = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = j_q + IdxW'(1);
        cmd_o.tap_ld  = 3'b010;
        cmd_o.coef2   = 1'b1;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        cmd_o.tap_ld = 3'b100;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.cur_we  = dir_q;
        cmd_o.nxt_we  = !dir_q;
        cmd_o.wr_addr = j_q;
        state_d = ST_RD0;
        if (j_q == last - IdxW'(1)) begin
          j_d   = IdxW'(1);
          dir_d = !dir_q;
          if (pass2_q) begin
            pass2_d = 1'b0;
            pairs_d = pairs_q - 16'd1;
            if (pairs_q == 16'd1) begin
              state_d = ST_DONE;
            end
          end else begin
            pass2_d = 1'b1;
          end
        end else begin
          j_d = j_q + IdxW'(1);
        end
      end
      ST_DONE: begin
        out_ld  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A pending result is never overwritten.
  `BSES_ASSERT(a_no_overwrite, out_ld |-> (!out_valid_q || !out_stall_i))
  // Only one grid is written in any cycle.
  `BSES_NEVER(a_one_write, cmd_o.cur_we && cmd_o.nxt_we)
  // Stencil writes stay on interior points.
  `BSES_ASSERT(a_interior, (state_q == ST_SUM) |-> (j_q != '0 && j_q < last))
  // A run ends only after the second pass of its last pair.
  `BSES_ASSERT(a_run_end, (state_q == ST_DONE) |-> (dir_q == 1'b0 && pairs_q == 16'd0))

endmodule

### design/black_scholes_explicit_stencil_unit.sv
// One-dimensional explicit finite-difference Black-Scholes stencil unit. Write and read
// words address one grid point; a read result comes from the registered grid memory read.
// A run word sweeps the P points in use: each interior point needs three reads through
// the single read port of the source grid, then coefficient, multiply and sum stages, and
// each pass pair sweeps the grid twice, ceil(time_steps/2) pairs per run. A run with fewer
// than three points or zero steps returns at once. Configuration writes are taken in any
// cycle and must only happen while idle.
module black_scholes_explicit_stencil_unit
  import bses_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      func_i,
  input  logic [IdxW-1:0] point_index_i,
  input  logic [31:0]     point_value_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [31:0]     read_value_o,
  output logic            status_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_index_i,
  input  logic [23:0]     cfg_data_i
);

  logic [17:0]     volatility_q;
  logic [15:0]     rate_q;
  logic [23:0]     delta_t_q;
  logic [15:0]     time_steps_q;
  logic [PtsW-1:0] grid_points_q;
  dp_cmd_t         cmd;
  dp_stat_t        stat;
  reg_e            cfg_reg;

  assign cfg_ready_o = 1'b1;
  assign cfg_reg     = reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volatility_q  <= 18'd20972;
      rate_q        <= 16'd2621;
      delta_t_q     <= 24'd16777;
      time_steps_q  <= 16'd0;
      grid_points_q <= PtsW'(1024);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg)
        REG_VOLATILITY: volatility_q  <= cfg_data_i[17:0];
        REG_RATE:       rate_q        <= cfg_data_i[15:0];
        REG_DELTA_T:    delta_t_q     <= cfg_data_i;
        REG_TIME_STEPS: time_steps_q  <= cfg_data_i[15:0];
        REG_GRID_PTS:   grid_points_q <= cfg_data_i[PtsW-1:0];
        default: ;
      endcase
    end
  end

  bses_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .point_index_i (point_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_value_o  (read_value_o),
    .status_o      (status_o),
    .time_steps_i  (time_steps_q),
    .grid_points_i (grid_points_q),
    .cmd_o         (cmd),
    .stat_i        (stat)
  );

  bses_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .point_value_i (point_value_i),
    .volatility_i  (volatility_q),
    .rate_i        (rate_q),
    .delta_t_i     (delta_t_q),
    .stat_o        (stat)
  );

endmodule
